>>> design/paafsm_pkg.sv
// shared types, codes and constants for the presence / absence alarm block
`timescale 1ns / 1ps

package paafsm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_TRIGGER = 2'd0;
  localparam logic [1:0] CFG_WARN    = 2'd1;
  localparam logic [1:0] CFG_END     = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [7:0]  TRIGGER_RST = 8'd5;
  localparam logic [15:0] WARN_RST    = 16'd5;
  localparam logic [15:0] END_RST     = 16'd10;

  // place state codes
  localparam logic [1:0] ST_IN   = 2'd0;
  localparam logic [1:0] ST_LEFT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  typedef struct packed {
    logic stable_in;
    logic stable_out;
  } run_status_t;

  typedef struct packed {
    logic [1:0]  place_state;
    logic        is_in_place;
    logic        alarm_on;
    logic        warning_pulse;
    logic        session_ended;
    logic [31:0] session_seconds;
    logic        welcome_pulse;
  } result_t;

endpackage

>>> design/paafsm_debounce.sv
// presence and absence run counters, saturating at the trigger count
`timescale 1ns / 1ps

module paafsm_debounce (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     present,
  input  logic [7:0]               trigger_frames,
  output paafsm_pkg::run_status_t  status
);

  logic [7:0] present_run_r, present_run_nxt;
  logic [7:0] absent_run_r, absent_run_nxt;

  always_comb begin
    present_run_nxt = present_run_r;
    absent_run_nxt  = absent_run_r;
    if (present) begin
      if (present_run_r < trigger_frames) present_run_nxt = present_run_r + 8'd1;
      absent_run_nxt = 8'd0;
    end else begin
      if (absent_run_r < trigger_frames) absent_run_nxt = absent_run_r + 8'd1;
      present_run_nxt = 8'd0;
    end
    status.stable_in  = present_run_nxt >= trigger_frames;
    status.stable_out = absent_run_nxt >= trigger_frames;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_run_r <= 8'd0;
      absent_run_r  <= 8'd0;
    end else if (step) begin
      present_run_r <= present_run_nxt;
      absent_run_r  <= absent_run_nxt;
    end
  end

endmodule

>>> design/paafsm_ctrl.sv
// place state machine with warning, session timing and welcome logic
`timescale 1ns / 1ps

module paafsm_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [31:0]              now_seconds,
  input  paafsm_pkg::run_status_t  status,
  input  logic [15:0]              warn_after_seconds,
  input  logic [15:0]              end_after_seconds,
  output paafsm_pkg::result_t      result
);

  logic [1:0]  place_r, place_nxt;
  logic [31:0] warn_start_r, warn_start_nxt;
  logic        warn_done_r, warn_done_nxt;
  logic        alarm_r, alarm_nxt;
  logic        sess_run_r, sess_run_nxt;
  logic [31:0] sess_start_r, sess_start_nxt;
  logic [31:0] elapsed;
  logic [31:0] warn_lim;
  logic [31:0] end_lim;
  logic        warn_pulse, ended, welcome;
  logic [31:0] length;

  assign elapsed  = now_seconds - warn_start_r;
  assign warn_lim = {16'd0, warn_after_seconds};
  assign end_lim  = {16'd0, end_after_seconds};

  always_comb begin
    place_nxt      = place_r;
    warn_start_nxt = warn_start_r;
    warn_done_nxt  = warn_done_r;
    alarm_nxt      = alarm_r;
    sess_run_nxt   = sess_run_r;
    sess_start_nxt = sess_start_r;
    warn_pulse     = 1'b0;
    ended          = 1'b0;
    welcome        = 1'b0;
    length         = 32'd0;
    case (place_r)
      paafsm_pkg::ST_LEFT: begin
        if (status.stable_in) begin
          place_nxt = paafsm_pkg::ST_IN;
          alarm_nxt = 1'b0;
        end else begin
          alarm_nxt = 1'b1;
          if ((elapsed > warn_lim) && (elapsed <= end_lim) && !warn_done_r) begin
            warn_pulse    = 1'b1;
            warn_done_nxt = 1'b1;
          end
          if (elapsed > end_lim) begin
            place_nxt    = paafsm_pkg::ST_OUT;
            ended        = 1'b1;
            length       = now_seconds - sess_start_r;
            sess_run_nxt = 1'b0;
          end
        end
      end
      paafsm_pkg::ST_OUT: begin
        alarm_nxt = 1'b0;
        if (status.stable_in) begin
          place_nxt    = paafsm_pkg::ST_IN;
          sess_run_nxt = 1'b0;
          welcome      = 1'b1;
        end
      end
      default: begin
        // in place, and the unused code treated the same way
        place_nxt = paafsm_pkg::ST_IN;
        if (!sess_run_r) begin
          sess_run_nxt   = 1'b1;
          sess_start_nxt = now_seconds;
        end
        if (status.stable_out) begin
          place_nxt      = paafsm_pkg::ST_LEFT;
          warn_start_nxt = now_seconds;
          warn_done_nxt  = 1'b0;
        end
      end
    endcase

    result.place_state     = place_nxt;
    result.is_in_place     = place_nxt == paafsm_pkg::ST_IN;
    result.alarm_on        = alarm_nxt;
    result.warning_pulse   = warn_pulse;
    result.session_ended   = ended;
    result.session_seconds = length;
    result.welcome_pulse   = welcome;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_r      <= paafsm_pkg::ST_IN;
      warn_start_r <= 32'd0;
      warn_done_r  <= 1'b0;
      alarm_r      <= 1'b0;
      sess_run_r   <= 1'b0;
      sess_start_r <= 32'd0;
    end else if (step) begin
      place_r      <= place_nxt;
      warn_start_r <= warn_start_nxt;
      warn_done_r  <= warn_done_nxt;
      alarm_r      <= alarm_nxt;
      sess_run_r   <= sess_run_nxt;
      sess_start_r <= sess_start_nxt;
    end
  end

endmodule

>>> design/presence_absence_alarm_fsm_top.sv
// top level of the presence / absence alarm: input stage, state logic, result stage
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   person_seen, position_ok, now_seconds
// out_      output     out_valid/out_stall place_state .. welcome_pulse
// cfg_      input      cfg_we              cfg_index, cfg_data
//
// one beat per cycle sustained while the output is not stalled; a taken beat is held in
// the input register, then passes through the state logic into the result register
// reset is synchronous, active low; state and config go to their power-up values
// a stalled result holds the result register; the input register still takes a
// beat if it is empty, so in_stall rises only once both stages are full

module presence_absence_alarm_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_person_seen,
  input  logic        in_position_ok,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_place_state,
  output logic        out_is_in_place,
  output logic        out_alarm_on,
  output logic        out_warning_pulse,
  output logic        out_session_ended,
  output logic [31:0] out_session_seconds,
  output logic        out_welcome_pulse,
  input  logic        cfg_we,
  input  logic [paafsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [paafsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [7:0]  trigger_r;
  logic [15:0] warn_r;
  logic [15:0] end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r <= paafsm_pkg::TRIGGER_RST;
      warn_r    <= paafsm_pkg::WARN_RST;
      end_r     <= paafsm_pkg::END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        paafsm_pkg::CFG_TRIGGER: trigger_r <= cfg_data[7:0];
        paafsm_pkg::CFG_WARN:    warn_r    <= cfg_data;
        paafsm_pkg::CFG_END:     end_r     <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // input stage
  logic        s1_valid_r;
  logic        s1_seen_r;
  logic        s1_pos_r;
  logic [31:0] s1_now_r;
  logic        s1_adv;
  logic        in_take;
  logic        out_valid_r;
  paafsm_pkg::result_t out_r;

  // the input beat moves on whenever the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_seen_r <= in_person_seen;
      s1_pos_r  <= in_position_ok;
      s1_now_r  <= in_now_seconds;
    end
  end

  // state logic; all state commits exactly when a beat moves into the result stage
  paafsm_pkg::run_status_t run_status;
  paafsm_pkg::result_t     res;

  paafsm_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_adv),
    .present        (s1_seen_r && s1_pos_r),
    .trigger_frames (trigger_r),
    .status         (run_status)
  );

  paafsm_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (s1_adv),
    .now_seconds        (s1_now_r),
    .status             (run_status),
    .warn_after_seconds (warn_r),
    .end_after_seconds  (end_r),
    .result             (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_r <= res;
  end

  assign out_valid           = out_valid_r;
  assign out_place_state     = out_r.place_state;
  assign out_is_in_place     = out_r.is_in_place;
  assign out_alarm_on        = out_r.alarm_on;
  assign out_warning_pulse   = out_r.warning_pulse;
  assign out_session_ended   = out_r.session_ended;
  assign out_session_seconds = out_r.session_seconds;
  assign out_welcome_pulse   = out_r.welcome_pulse;

  // checks

  // a session end always lands out of place
  a_end_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_session_ended) |-> (out_place_state == paafsm_pkg::ST_OUT))
    else $error("session end without out of place state");

  // a welcome always lands in place
  a_welcome_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_welcome_pulse) |-> (out_is_in_place && !out_alarm_on))
    else $error("welcome pulse while not in place");

  // the session length is only reported on the ending beat
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_session_ended) |-> (out_session_seconds == 32'd0))
    else $error("session length reported without session end");

  // a warning is only raised while the alarm is sounding
  a_warn_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_warning_pulse) |-> out_alarm_on)
    else $error("warning pulse without alarm");

  // both stages full and the output stalled must push back on the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while both stages are blocked");

endmodule

>>> tb/tb_presence_absence_alarm_fsm_top.sv
// self-checking testbench for the presence / absence alarm block
`timescale 1ns / 1ps

module tb_presence_absence_alarm_fsm_top;

  localparam int HOLD_CYCLES = 40;   // long receiver hold-off so both stages fill up

  // tracks the alarm state machine and holds the status beats still to come
  class absence_scoreboard;
    logic [7:0]  trig;
    logic [15:0] warn_s;
    logic [15:0] end_s;
    logic [1:0]  place;
    logic [7:0]  pres_run;
    logic [7:0]  abs_run;
    logic [31:0] away_since;
    logic        warned;
    logic        alarm;
    logic        in_session;
    logic [31:0] session_t0;
    paafsm_pkg::result_t expected_status[$];
    int unsigned failures;

    function new();
      trig       = paafsm_pkg::TRIGGER_RST;
      warn_s     = paafsm_pkg::WARN_RST;
      end_s      = paafsm_pkg::END_RST;
      place      = paafsm_pkg::ST_IN;
      pres_run   = '0;
      abs_run    = '0;
      away_since = '0;
      warned     = 1'b0;
      alarm      = 1'b0;
      in_session = 1'b0;
      session_t0 = '0;
      failures   = 0;
    endfunction

    function void apply_reg(logic [paafsm_pkg::CFG_IDX_W-1:0] idx,
                            logic [paafsm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        paafsm_pkg::CFG_TRIGGER: trig   = data[7:0];
        paafsm_pkg::CFG_WARN:    warn_s = data;
        paafsm_pkg::CFG_END:     end_s  = data;
        default: ;
      endcase
    endfunction

    // one frame in, one status beat expected
    function void note_frame(logic seen, logic pos_ok, logic [31:0] stamp);
      logic        present;
      logic        stable_in;
      logic        stable_out;
      logic [31:0] elapsed;
      paafsm_pkg::result_t r;
      present = seen & pos_ok;
      r = '0;
      if (present) begin
        if (pres_run < trig) pres_run = pres_run + 8'd1;
        abs_run = '0;
      end else begin
        if (abs_run < trig) abs_run = abs_run + 8'd1;
        pres_run = '0;
      end
      stable_in  = (pres_run >= trig);
      stable_out = (abs_run >= trig);
      case (place)
        paafsm_pkg::ST_LEFT: begin
          if (stable_in) begin
            place = paafsm_pkg::ST_IN;
            alarm = 1'b0;
          end else begin
            elapsed = stamp - away_since;
            alarm = 1'b1;
            if (elapsed > warn_s && elapsed <= end_s && !warned) begin
              r.warning_pulse = 1'b1;
              warned = 1'b1;
            end
            if (elapsed > end_s) begin
              place = paafsm_pkg::ST_OUT;
              r.session_ended = 1'b1;
              r.session_seconds = stamp - session_t0;
              in_session = 1'b0;
            end
          end
        end
        paafsm_pkg::ST_OUT: begin
          alarm = 1'b0;
          if (stable_in) begin
            place = paafsm_pkg::ST_IN;
            in_session = 1'b0;
            r.welcome_pulse = 1'b1;
          end
        end
        default: begin
          place = paafsm_pkg::ST_IN;
          if (!in_session) begin
            in_session = 1'b1;
            session_t0 = stamp;
          end
          if (stable_out) begin
            place = paafsm_pkg::ST_LEFT;
            away_since = stamp;
            warned = 1'b0;
          end
        end
      endcase
      r.place_state = place;
      r.is_in_place = (place == paafsm_pkg::ST_IN);
      r.alarm_on    = alarm;
      expected_status = {expected_status, r};
    endfunction

    function void field_ok(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
      end
    endfunction

    function void check_status(paafsm_pkg::result_t got);
      paafsm_pkg::result_t want;
      if (expected_status.size() == 0) begin
        failures++;
        $display("%0t: status beat with nothing expected, actual %0h", $time, got);
        return;
      end
      want = expected_status.pop_front();
      field_ok("place_state", 32'(want.place_state), 32'(got.place_state));
      field_ok("is_in_place", 32'(want.is_in_place), 32'(got.is_in_place));
      field_ok("alarm_on", 32'(want.alarm_on), 32'(got.alarm_on));
      field_ok("warning_pulse", 32'(want.warning_pulse), 32'(got.warning_pulse));
      field_ok("session_ended", 32'(want.session_ended), 32'(got.session_ended));
      field_ok("session_seconds", want.session_seconds, got.session_seconds);
      field_ok("welcome_pulse", 32'(want.welcome_pulse), 32'(got.welcome_pulse));
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic                              in_person_seen;
  logic                              in_position_ok;
  logic [31:0]                       in_now_seconds;
  logic                              out_valid;
  logic                              out_stall;
  logic [1:0]                        out_place_state;
  logic                              out_is_in_place;
  logic                              out_alarm_on;
  logic                              out_warning_pulse;
  logic                              out_session_ended;
  logic [31:0]                       out_session_seconds;
  logic                              out_welcome_pulse;
  logic                              cfg_we;
  logic [paafsm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [paafsm_pkg::CFG_DATA_W-1:0] cfg_data;

  absence_scoreboard board = new();

  // receiver controls, set by the main sequence
  bit          recv_gaps = 1'b1;
  bit          hold_req  = 1'b0;
  // running frame timestamp for the random part
  logic [31:0] frame_clock = '0;

  presence_absence_alarm_fsm_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_person_seen      (in_person_seen),
    .in_position_ok      (in_position_ok),
    .in_now_seconds      (in_now_seconds),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_place_state     (out_place_state),
    .out_is_in_place     (out_is_in_place),
    .out_alarm_on        (out_alarm_on),
    .out_warning_pulse   (out_warning_pulse),
    .out_session_ended   (out_session_ended),
    .out_session_seconds (out_session_seconds),
    .out_welcome_pulse   (out_welcome_pulse),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req  = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // status monitor: every taken result beat goes to the scoreboard
  always @(posedge clk) begin
    paafsm_pkg::result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.place_state     = out_place_state;
      got.is_in_place     = out_is_in_place;
      got.alarm_on        = out_alarm_on;
      got.warning_pulse   = out_warning_pulse;
      got.session_ended   = out_session_ended;
      got.session_seconds = out_session_seconds;
      got.welcome_pulse   = out_welcome_pulse;
      board.check_status(got);
    end
  end

  // offer one frame and hold it until the block takes it
  task automatic drive_frame(input logic seen, input logic pos_ok, input logic [31:0] stamp);
    @(negedge clk);
    in_valid       = 1'b1;
    in_person_seen = seen;
    in_position_ok = pos_ok;
    in_now_seconds = stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_frame(seen, pos_ok, stamp);
  endtask

  // sender gap whose length is set by n
  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // wait until every status beat is back and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [paafsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [paafsm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    board.apply_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // all three registers; junk in the upper byte of the trigger write must be ignored
  task automatic write_settings(input logic [7:0] trig_val, input logic [15:0] warn_val,
                                input logic [15:0] limit_val);
    settle();
    write_reg(paafsm_pkg::CFG_TRIGGER, {8'($urandom), trig_val});
    write_reg(paafsm_pkg::CFG_WARN, warn_val);
    write_reg(paafsm_pkg::CFG_END, limit_val);
  endtask

  // next timestamp: mostly small steps scaled to the end limit, some stalls and wild jumps
  function automatic logic [31:0] next_stamp(logic [31:0] t);
    int unsigned pick;
    logic [31:0] span;
    pick = $urandom_range(0, 19);
    span = ({16'd0, board.end_s} >> 2) + 32'd2;
    if (pick == 0) return t + $urandom;
    if (pick == 1) return t;
    return t + $urandom_range(0, span);
  endfunction

  // runs of present / absent frames around the trigger count, with some noise frames
  task automatic run_random(input int count, input bit gaps_on);
    int   remaining;
    int   run_len;
    int   lo;
    bit   want_present;
    bit   gap_run;
    logic [1:0] bits;
    remaining = count;
    want_present = $urandom_range(0, 1);
    while (remaining > 0) begin
      lo = (board.trig > 2) ? board.trig - 2 : 1;
      if ($urandom_range(0, 3) == 0) run_len = $urandom_range(1, 4);
      else run_len = $urandom_range(lo, board.trig + 3);
      gap_run = gaps_on && ($urandom_range(0, 9) < 7);
      repeat (run_len) begin
        if (remaining > 0) begin
          if ($urandom_range(0, 9) == 0) bits = 2'($urandom_range(0, 3));
          else if (want_present) bits = 2'b11;
          else bits = 2'($urandom_range(0, 2));  // any of 00, 01, 10 means absent
          frame_clock = next_stamp(frame_clock);
          drive_frame(bits[1], bits[0], frame_clock);
          remaining--;
          if (gap_run && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 9));
        end
      end
      want_present = !want_present;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_person_seen = 1'b0;
    in_position_ok = 1'b0;
    in_now_seconds = '0;
    cfg_we         = 1'b0;
    cfg_index      = paafsm_pkg::CFG_TRIGGER;
    cfg_data       = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: single-frame debounce, short limits, timestamps wrapping through zero
    write_settings(8'd1, 16'd2, 16'd4);
    drive_frame(1'b1, 1'b1, 32'hFFFF_FFFE);  // session starts just below the wrap
    drive_frame(1'b1, 1'b0, 32'hFFFF_FFFF);  // seen but outside the area: leaves
    drive_frame(1'b0, 1'b1, 32'h0000_0000);  // alarm on, no warning yet
    drive_frame(1'b0, 1'b0, 32'd2);          // warning pulse
    drive_frame(1'b0, 1'b0, 32'd3);          // warning only once
    drive_frame(1'b0, 1'b0, 32'd4);          // session ends, length across the wrap
    drive_frame(1'b0, 1'b0, 32'd5);          // out of place, alarm drops
    drive_frame(1'b1, 1'b1, 32'd6);          // welcome back
    drive_frame(1'b1, 1'b1, 32'd7);          // new session starts
    drive_frame(1'b0, 1'b0, 32'd8);          // leaves
    drive_frame(1'b1, 1'b1, 32'd9);          // back before the end, session keeps running
    drive_frame(1'b0, 1'b1, 32'd10);         // leaves again
    drive_frame(1'b1, 1'b1, 32'd100);        // back even though the end is long past
    drive_frame(1'b0, 1'b0, 32'd101);        // leaves
    drive_frame(1'b0, 1'b0, 32'd200);        // jumps straight past the end, no warning
    drive_frame(1'b1, 1'b1, 32'd201);        // welcome back

    // warning limit equal to the end limit: the warning can never fire
    write_settings(8'd1, 16'd4, 16'd4);
    drive_frame(1'b0, 1'b1, 32'd202);
    drive_frame(1'b0, 1'b0, 32'd206);
    drive_frame(1'b0, 1'b0, 32'd207);

    // zero trigger and zero limits: presence and absence both stable every frame
    write_settings(8'd0, 16'd0, 16'd0);
    drive_frame(1'b0, 1'b0, 32'd208);
    drive_frame(1'b1, 1'b1, 32'd209);
    drive_frame(1'b1, 1'b1, 32'd210);
    drive_frame(1'b0, 1'b0, 32'hFFFF_FFFF);
    drive_frame(1'b0, 1'b0, 32'h0000_0000);
    frame_clock = '0;

    // random phases with both sides idling
    write_settings(8'd1, 16'd2, 16'd6);
    run_random(70, 1'b1);

    // power-up settings; receiver holds off while frames keep coming
    write_settings(paafsm_pkg::TRIGGER_RST, paafsm_pkg::WARN_RST, paafsm_pkg::END_RST);
    hold_req = 1'b1;
    run_random(20, 1'b0);
    run_random(60, 1'b1);

    write_settings(8'd0, 16'd0, 16'd0);
    run_random(30, 1'b1);

    // widest settings: trigger at the top of its 8-bit range, limits at full scale
    write_settings(8'd255, 16'hFFFF, 16'hFFFF);
    run_random(190, 1'b1);

    // last part: random settings, no idling on either side
    write_settings(8'($urandom_range(1, 8)), 16'($urandom_range(0, 20)),
                   16'($urandom_range(0, 30)));
    recv_gaps = 1'b0;
    run_random(60, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (board.failures == 0 && board.expected_status.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
